// File: sv/psas_pkg.sv
// shared constants and types for the pixel sampling address stepper
`default_nettype none
package psas_pkg;

  localparam int CFG_DW = 13;
  localparam int OUT_W  = 12;
  localparam int DET_W  = 4;
  localparam int CIDX_W = 2;

  localparam logic [CIDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic              MODE_RASTER  = 1'b0;
  localparam logic              MODE_HILBERT = 1'b1;
  localparam logic [CFG_DW-1:0] DIM_RST      = 13'd4096;

  typedef struct packed {
    logic start;
    logic to_point;
  } curve_cmd_t;

endpackage
`default_nettype wire

// File: sv/psas_rem_unit.sv
// shift-subtract remainder unit, one numerator bit per cycle
`default_nettype none
module psas_rem_unit #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 26
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [DEN_W-1:0]      rem
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [CW-1:0]    cnt_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(NUM_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      num_r <= num_r << 1;
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// File: sv/psas_curve_unit.sv
// bit-serial hilbert converter: point to index (msb first) or index to point (lsb first)
`default_nettype none
module psas_curve_unit
  import psas_pkg::*;
#(
  parameter int PW = 12,
  localparam int PLW = $clog2(PW + 1),
  localparam int IW = 2 * PW
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire curve_cmd_t     cmd,
  input  wire logic [PLW-1:0] p,
  input  wire logic [PW-1:0]  x_in,
  input  wire logic [PW-1:0]  y_in,
  input  wire logic [IW-1:0]  d_in,
  output logic [PW-1:0]       x_out,
  output logic [PW-1:0]       y_out,
  output logic [IW-1:0]       d_out,
  output logic                done
);

  logic           to_point_r;
  logic [PLW-1:0] cnt_r;
  logic           done_r;
  logic [PW-1:0]  x_r, y_r, bit_r, mask_r;
  logic [IW-1:0]  d_r;

  logic [PLW-1:0] align;
  logic           qx_i, qy_i, qx_p, qy_p;
  logic [PW-1:0]  xt_i, yt_i, xt_p, yt_p;
  logic [PW-1:0]  x_nxt, y_nxt;
  logic [IW-1:0]  d_nxt;
  logic [IW+1:0]  d_cat;

  assign align = PLW'(PW) - p;

  always_comb begin
    // index direction: top valid bit sits at the msb, window shifts left
    qx_i = x_r[PW-1];
    qy_i = y_r[PW-1];
    xt_i = x_r;
    yt_i = y_r;
    if (!qy_i) begin
      if (qx_i) begin
        xt_i = ~y_r;
        yt_i = ~x_r;
      end else begin
        xt_i = y_r;
        yt_i = x_r;
      end
    end
    d_cat = {d_r, qx_i, qx_i ^ qy_i};

    // point direction: grow the square one bit per step
    qx_p = d_r[1];
    qy_p = d_r[0] ^ d_r[1];
    xt_p = x_r;
    yt_p = y_r;
    if (!qy_p) begin
      if (qx_p) begin
        xt_p = ~y_r & mask_r;
        yt_p = ~x_r & mask_r;
      end else begin
        xt_p = y_r;
        yt_p = x_r;
      end
    end

    if (to_point_r) begin
      x_nxt = xt_p | (qx_p ? bit_r : '0);
      y_nxt = yt_p | (qy_p ? bit_r : '0);
      d_nxt = d_r >> 2;
    end else begin
      x_nxt = xt_i << 1;
      y_nxt = yt_i << 1;
      d_nxt = d_cat[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        cnt_r  <= p;
        done_r <= (p == '0);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - PLW'(1);
        if (cnt_r == PLW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      to_point_r <= cmd.to_point;
      bit_r      <= PW'(1);
      mask_r     <= '0;
      if (cmd.to_point) begin
        x_r <= '0;
        y_r <= '0;
        d_r <= d_in;
      end else begin
        x_r <= x_in << align;
        y_r <= y_in << align;
        d_r <= '0;
      end
    end else if (cnt_r != '0) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      d_r    <= d_nxt;
      mask_r <= mask_r | bit_r;
      bit_r  <= bit_r << 1;
    end
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign d_out = d_r;
  assign done  = done_r;

endmodule
`default_nettype wire

// File: sv/pixel_sampling_address_stepper.sv
// pixel sampling address stepper: raster or hilbert walk over a bitmap
// result: sample_x/sample_y of the current position is presented the cycle after the transfer
// raster update: prep, stride and step states, plus remainder unit when the row index wraps
// past the height; hilbert update: those states, point to index (p = floor log2 width, one
// curve bit a cycle), remainder unit on index wrap, index to point; next transfer after that
// sync reset: raster mode, 4096 x 4096, position (0,0); mode/width/height writes zero position
`default_nettype none
module pixel_sampling_address_stepper
  import psas_pkg::*;
#(
  parameter int MAX_SIDE_LOG2 = 12
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [DET_W-1:0]  in_detail,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [OUT_W-1:0]       out_sample_x,
  output logic [OUT_W-1:0]       out_sample_y
);

  localparam int PW  = (MAX_SIDE_LOG2 < CFG_DW) ? MAX_SIDE_LOG2 : CFG_DW;
  localparam int PLW = $clog2(PW + 1);
  localparam int DMW = PW + 1;
  localparam int IW  = 2 * PW;
  localparam int NW  = IW + 1;
  localparam int AW  = 2 * DMW;
  localparam int EW  = 6;
  localparam logic [31:0] DIM_LIM = 32'd1 << MAX_SIDE_LOG2;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_STRIDE = 3'd2;
  localparam logic [2:0] S_DISP   = 3'd3;
  localparam logic [2:0] S_REMY   = 3'd4;
  localparam logic [2:0] S_IDX    = 3'd5;
  localparam logic [2:0] S_REMD   = 3'd6;
  localparam logic [2:0] S_PT     = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic              mode_r;
  logic [CFG_DW-1:0] width_r, height_r;
  logic [PW-1:0]     pos_x_r, pos_y_r;
  logic [DET_W-1:0]  detail_r;
  logic [PLW-1:0]    p_r;
  logic [DMW-1:0]    w_r, h_r;
  logic [AW-1:0]     area_r;
  logic [PW-1:0]     stride_r;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_x_r, out_y_r;

  logic              cfg_fire, in_fire;
  logic [DMW-1:0]    w_c, h_c;
  logic [PLW-1:0]    p_c;
  logic [PW-1:0]     stride_c;
  logic [EW-1:0]     p_e, det_e;
  logic [DMW-1:0]    x_sum, y_sum;
  logic              x_ov, y_ov;
  logic [NW-1:0]     d_sum;
  logic              d_wrap;

  logic              rem_start, rem_done;
  logic [NW-1:0]     rem_num;
  logic [AW-1:0]     rem_den, rem_val;
  curve_cmd_t        c_cmd;
  logic [IW-1:0]     c_d_in, c_d_out;
  logic [PW-1:0]     c_x_out, c_y_out;
  logic              c_done;

  function automatic logic [DMW-1:0] clamp_dim(input logic [CFG_DW-1:0] v);
    logic [DMW-1:0] c;
    if (v == '0) begin
      c = DMW'(1);
    end else if (32'(v) > DIM_LIM) begin
      c = DMW'(DIM_LIM);
    end else begin
      c = DMW'(v);
    end
    return c;
  endfunction

  assign w_c = clamp_dim(width_r);
  assign h_c = clamp_dim(height_r);

  // floor log2 of the clamped width
  always_comb begin
    p_c = '0;
    for (int i = 0; i < DMW; i++) begin
      if (w_c[i]) begin
        p_c = PLW'(i);
      end
    end
  end

  always_comb begin
    p_e      = EW'(p_r);
    det_e    = EW'(detail_r);
    stride_c = PW'(1);
    if (p_e > det_e + EW'(1)) begin
      stride_c = PW'(1) << (p_e - det_e - EW'(1));
    end
  end

  assign x_sum  = DMW'(pos_x_r) + DMW'(stride_r);
  assign y_sum  = DMW'(pos_y_r) + DMW'(stride_r);
  assign x_ov   = x_sum >= w_r;
  assign y_ov   = y_sum >= h_r;
  assign d_sum  = NW'(c_d_out) + NW'(stride_r);
  assign d_wrap = AW'(d_sum) >= area_r;

  assign cfg_ready = (state_r == S_IDLE);
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = (state_r == S_IDLE) && !cfg_valid && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;

  assign rem_start = ((state_r == S_DISP) && (mode_r == MODE_RASTER) && x_ov && y_ov)
                  || ((state_r == S_IDX) && c_done && d_wrap);
  assign rem_num   = (state_r == S_DISP) ? NW'(y_sum) : d_sum;
  assign rem_den   = (state_r == S_DISP) ? AW'(h_r) : area_r;

  assign c_cmd.start    = ((state_r == S_DISP) && (mode_r == MODE_HILBERT))
                       || ((state_r == S_IDX) && c_done && !d_wrap)
                       || ((state_r == S_REMD) && rem_done);
  assign c_cmd.to_point = (state_r != S_DISP);
  assign c_d_in         = (state_r == S_REMD) ? IW'(rem_val) : IW'(d_sum);

  psas_rem_unit #(
    .NUM_W(NW),
    .DEN_W(AW)
  ) u_rem (
    .clk  (clk),
    .rst_n(rst_n),
    .start(rem_start),
    .num  (rem_num),
    .den  (rem_den),
    .done (rem_done),
    .rem  (rem_val)
  );

  psas_curve_unit #(
    .PW(PW)
  ) u_curve (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (c_cmd),
    .p    (p_r),
    .x_in (pos_x_r),
    .y_in (pos_y_r),
    .d_in (c_d_in),
    .x_out(c_x_out),
    .y_out(c_y_out),
    .d_out(c_d_out),
    .done (c_done)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP:   state_nxt = S_STRIDE;
      S_STRIDE: state_nxt = S_DISP;
      S_DISP: begin
        if (mode_r == MODE_HILBERT) begin
          state_nxt = S_IDX;
        end else if (x_ov && y_ov) begin
          state_nxt = S_REMY;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_REMY: begin
        if (rem_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDX: begin
        if (c_done) begin
          state_nxt = d_wrap ? S_REMD : S_PT;
        end
      end
      S_REMD: begin
        if (rem_done) begin
          state_nxt = S_PT;
        end
      end
      S_PT: begin
        if (c_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_RASTER;
      width_r     <= DIM_RST;
      height_r    <= DIM_RST;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_fire) begin
        unique case (cfg_index)
          REG_MODE: begin
            mode_r  <= cfg_data[0];
            pos_x_r <= '0;
            pos_y_r <= '0;
          end
          REG_WIDTH: begin
            width_r <= cfg_data;
            pos_x_r <= '0;
            pos_y_r <= '0;
          end
          REG_HEIGHT: begin
            height_r <= cfg_data;
            pos_x_r  <= '0;
            pos_y_r  <= '0;
          end
          default: ;
        endcase
      end
      // raster: x wraps at most once per step
      if (state_r == S_DISP && mode_r == MODE_RASTER) begin
        if (x_ov) begin
          pos_x_r <= PW'(x_sum - w_r);
          if (!y_ov) begin
            pos_y_r <= PW'(y_sum);
          end
        end else begin
          pos_x_r <= PW'(x_sum);
        end
      end
      if (state_r == S_REMY && rem_done) begin
        pos_y_r <= PW'(rem_val);
      end
      if (state_r == S_PT && c_done) begin
        pos_x_r <= c_x_out;
        pos_y_r <= c_y_out;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      detail_r <= in_detail;
      out_x_r  <= OUT_W'(pos_x_r);
      out_y_r  <= OUT_W'(pos_y_r);
    end
    if (state_r == S_PREP) begin
      p_r    <= p_c;
      w_r    <= w_c;
      h_r    <= h_c;
      area_r <= AW'(w_c) * AW'(h_c);
    end
    if (state_r == S_STRIDE) begin
      stride_r <= stride_c;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_sample_x = out_x_r;
  assign out_sample_y = out_y_r;

endmodule
`default_nettype wire

// File: bench/tb_pixel_sampling_address_stepper.sv
// self-checking bench for the pixel sampling address stepper: directed table, then random bursts
`timescale 1ns / 1ps
module tb_pixel_sampling_address_stepper
  import psas_pkg::*;
();

  localparam int SIDE_LOG2 = 12;
  localparam int SETTLE = 120;
  localparam int RAND_ITEMS = 1150;
  localparam int TIMEOUT_NS = 18_000_000;
  localparam logic [CIDX_W-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
  } sample_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_FIXED, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [CIDX_W-1:0] idx;
    logic [CFG_DW-1:0] data;
    logic [DET_W-1:0]  det;
    logic [OUT_W-1:0]  ex;
    logic [OUT_W-1:0]  ey;
  } plan_row_t;

  localparam int PLAN_LEN = 35;
  localparam plan_row_t PLAN [0:PLAN_LEN-1] = '{
    '{ROW_FIXED, REG_MODE,   13'd0,     4'd0,  12'd0,    12'd0},
    '{ROW_FIXED, REG_MODE,   13'd0,     4'd15, 12'd2048, 12'd0},
    '{ROW_ITEM,  REG_MODE,   13'd0,     4'd10, 12'd0,    12'd0},
    '{ROW_ITEM,  REG_MODE,   13'd0,     4'd11, 12'd0,    12'd0},
    '{ROW_WRITE, REG_WIDTH,  13'd0,     4'd0,  12'd0,    12'd0},
    '{ROW_FIXED, REG_MODE,   13'd0,     4'd0,  12'd0,    12'd0},
    '{ROW_ITEM,  REG_MODE,   13'd0,     4'd15, 12'd0,    12'd0},
    '{ROW_ITEM,  REG_MODE,   13'd0,     4'd7,  12'd0,    12'd0},
    '{ROW_WRITE, REG_WIDTH,  13'd8191,  4'd0,  12'd0,    12'd0},
    '{ROW_FIXED, REG_MODE,   13'd0,     4'd0,  12'd0,    12'd0},
    '{ROW_ITEM,  REG_MODE,   13'd0,     4'd0,  12'd0,    12'd0},
    '{ROW_ITEM,  REG_MODE,   13'd0,     4'd0,  12'd0,    12'd0},
    '{ROW_WRITE, REG_HEIGHT, 13'd0,     4'd0,  12'd0,    12'd0},
    '{ROW_FIXED, REG_MODE,   13'd0,     4'd0,  12'd0,    12'd0},
    '{ROW_ITEM,  REG_MODE,   13'd0,     4'd0,  12'd0,    12'd0},
    '{ROW_WRITE, REG_HEIGHT, 13'd8191,  4'd0,  12'd0,    12'd0},
    '{ROW_WRITE, REG_MODE,   13'h1FFF,  4'd0,  12'd0,    12'd0},
    '{ROW_FIXED, REG_MODE,   13'd0,     4'd0,  12'd0,    12'd0},
    '{ROW_ITEM,  REG_MODE,   13'd0,     4'd15, 12'd0,    12'd0},
    '{ROW_WRITE, REG_WIDTH,  13'd8,     4'd0,  12'd0,    12'd0},
    '{ROW_WRITE, REG_HEIGHT, 13'd8,     4'd0,  12'd0,    12'd0},
    '{ROW_FIXED, REG_MODE,   13'd0,     4'd0,  12'd0,    12'd0},
    '{ROW_ITEM,  REG_MODE,   13'd0,     4'd0,  12'd0,    12'd0},
    '{ROW_ITEM,  REG_MODE,   13'd0,     4'd0,  12'd0,    12'd0},
    '{ROW_ITEM,  REG_MODE,   13'd0,     4'd1,  12'd0,    12'd0},
    '{ROW_WRITE, REG_NONE,   13'h1ABC,  4'd0,  12'd0,    12'd0},
    '{ROW_ITEM,  REG_MODE,   13'd0,     4'd2,  12'd0,    12'd0},
    '{ROW_ITEM,  REG_MODE,   13'd0,     4'd15, 12'd0,    12'd0},
    '{ROW_WRITE, REG_WIDTH,  13'd4096,  4'd0,  12'd0,    12'd0},
    '{ROW_WRITE, REG_HEIGHT, 13'd4096,  4'd0,  12'd0,    12'd0},
    '{ROW_FIXED, REG_MODE,   13'd0,     4'd0,  12'd0,    12'd0},
    '{ROW_ITEM,  REG_MODE,   13'd0,     4'd0,  12'd0,    12'd0},
    '{ROW_WRITE, REG_MODE,   13'h1FFE,  4'd0,  12'd0,    12'd0},
    '{ROW_FIXED, REG_MODE,   13'd0,     4'd3,  12'd0,    12'd0},
    '{ROW_ITEM,  REG_MODE,   13'd0,     4'd3,  12'd0,    12'd0}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [DET_W-1:0]  in_detail = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [OUT_W-1:0]  out_sample_x;
  logic [OUT_W-1:0]  out_sample_y;

  pixel_sampling_address_stepper #(.MAX_SIDE_LOG2(SIDE_LOG2)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_detail    (in_detail),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sample_x (out_sample_x),
    .out_sample_y (out_sample_y)
  );

  always #6 clk = ~clk;

  // shadow of the block's registers and walk position
  logic              cur_mode = MODE_RASTER;
  logic [CFG_DW-1:0] cur_width = DIM_RST;
  logic [CFG_DW-1:0] cur_height = DIM_RST;
  int unsigned       walk_x = 0;
  int unsigned       walk_y = 0;

  sample_t pending_samples [$];

  int  in_idle_pct = 35;
  int  out_idle_pct = 80;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;
  int  n_items = 0;
  int  n_curve = 0;
  int  n_writes = 0;
  int  n_settings = 0;
  int  n_checked = 0;
  int  n_errors = 0;

  function automatic int unsigned eff_dim(input logic [CFG_DW-1:0] v);
    if (v == 0) return 1;
    if (v > (1 << SIDE_LOG2)) return 1 << SIDE_LOG2;
    return 32'(v);
  endfunction

  function automatic int unsigned side_log2(input int unsigned v);
    int unsigned n;
    int unsigned k;
    n = 0;
    k = v;
    while (k > 1) begin
      k >>= 1;
      n++;
    end
    return n;
  endfunction

  function automatic void quad_flip(input int unsigned side, inout int unsigned x,
                                    inout int unsigned y, input int unsigned qx,
                                    input int unsigned qy);
    int unsigned t;
    if (qy == 0) begin
      if (qx != 0) begin
        x = side - 1 - x;
        y = side - 1 - y;
      end
      t = x;
      x = y;
      y = t;
    end
  endfunction

  function automatic int unsigned curve_pos(input int unsigned p, input int unsigned px,
                                            input int unsigned py);
    int unsigned side;
    int unsigned x;
    int unsigned y;
    int unsigned d;
    int unsigned s;
    int unsigned qx;
    int unsigned qy;
    side = 1 << p;
    x = px & (side - 1);
    y = py & (side - 1);
    d = 0;
    for (s = side >> 1; s > 0; s >>= 1) begin
      qx = ((x & s) != 0) ? 1 : 0;
      qy = ((y & s) != 0) ? 1 : 0;
      d += s * s * ((3 * qx) ^ qy);
      quad_flip(side, x, y, qx, qy);
    end
    return d;
  endfunction

  // only the low 2*p index bits take part
  function automatic void curve_xy(input int unsigned p, input int unsigned d,
                                   output int unsigned x, output int unsigned y);
    int unsigned k;
    int unsigned qx;
    int unsigned qy;
    k = d;
    x = 0;
    y = 0;
    for (int unsigned i = 0; i < p; i++) begin
      qx = (k >> 1) & 1;
      qy = (k ^ qx) & 1;
      quad_flip(1 << i, x, y, qx, qy);
      x += qx << i;
      y += qy << i;
      k >>= 2;
    end
  endfunction

  function automatic sample_t take_sample(input logic [DET_W-1:0] det);
    sample_t     r;
    int unsigned w;
    int unsigned h;
    int unsigned p;
    int unsigned dv;
    int unsigned stride;
    int unsigned d;
    w = eff_dim(cur_width);
    h = eff_dim(cur_height);
    p = side_log2(w);
    dv = 32'(det);
    stride = 1;
    r.x = OUT_W'(walk_x);
    r.y = OUT_W'(walk_y);
    if (p > dv + 1) stride = 1 << (p - dv - 1);
    if (cur_mode == MODE_RASTER) begin
      walk_x += stride;
      if (walk_x >= w) begin
        walk_y += (walk_x / w) * stride;
        walk_x %= w;
        walk_y %= h;
      end
    end else begin
      d = curve_pos(p, walk_x, walk_y) + stride;
      if (d >= w * h) d = d % (w * h);
      curve_xy(p, d, walk_x, walk_y);
    end
    return r;
  endfunction

  function automatic void apply_reg(input logic [CIDX_W-1:0] idx,
                                    input logic [CFG_DW-1:0] val);
    case (idx)
      REG_MODE:   cur_mode = val[0];
      REG_WIDTH:  cur_width = val;
      REG_HEIGHT: cur_height = val;
      default:    return;
    endcase
    walk_x = 0;
    walk_y = 0;
  endfunction

  function automatic logic [CFG_DW-1:0] pick_value(input logic [CIDX_W-1:0] idx);
    if (idx == REG_WIDTH || idx == REG_HEIGHT) begin
      case ($urandom_range(9))
        0:          return '0;
        1:          return CFG_DW'(1);
        2:          return DIM_RST;
        3:          return CFG_DW'($urandom_range(8191, 4097));
        4, 5, 6, 7: return CFG_DW'($urandom_range(64, 1));
        8:          return CFG_DW'(1 << $urandom_range(6, 0));
        default:    return CFG_DW'($urandom_range(8191));
      endcase
    end
    return CFG_DW'($urandom_range(8191));
  endfunction

  // valid is left high after the transfer; the next call or wait_quiet decides
  task automatic send_item(input logic [DET_W-1:0] det, input bit fixed,
                           input sample_t fixed_val);
    sample_t guess;
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_detail <= det;
    do @(posedge clk); while (!in_ready);
    if (cur_mode == MODE_HILBERT) n_curve++;
    guess = take_sample(det);
    pending_samples.push_back(fixed ? fixed_val : guess);
    n_items++;
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    n_writes++;
  endtask

  // the position update runs on after the sample leaves, so let it finish too
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_samples.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    sample_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected sample: expected none, got (%0d,%0d)", $time,
                 out_sample_x, out_sample_y);
      end else begin
        want = pending_samples.pop_front();
        n_checked++;
        if (out_sample_x !== want.x) begin
          n_errors++;
          $display("%0t: sample_x mismatch: expected %0d, got %0d", $time, want.x,
                   out_sample_x);
        end
        if (out_sample_y !== want.y) begin
          n_errors++;
          $display("%0t: sample_y mismatch: expected %0d, got %0d", $time, want.y,
                   out_sample_y);
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d samples outstanding", pending_samples.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    plan_row_t row;
    bit        prev_write;
    int        sent;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    prev_write = 1'b0;
    for (int i = 0; i < PLAN_LEN; i++) begin
      row = PLAN[i];
      if (row.kind == ROW_WRITE) begin
        if (!prev_write) wait_quiet();
        write_reg(row.idx, row.data);
        prev_write = 1'b1;
      end else begin
        if (prev_write) cfg_valid <= 1'b0;
        send_item(row.det, row.kind == ROW_FIXED, sample_t'({row.ex, row.ey}));
        prev_write = 1'b0;
      end
    end

    sent = 0;
    while (sent < RAND_ITEMS) begin
      if (sent < RAND_ITEMS / 3) begin
        in_idle_pct = 35;
        out_idle_pct = 80;
      end else if (sent < 2 * RAND_ITEMS / 3) begin
        in_idle_pct = 80;
        out_idle_pct = 35;
      end else begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      wait_quiet();
      for (int r = 0; r <= REG_NONE; r++) begin
        if ($urandom_range(99) < ((r == REG_NONE) ? 15 : 60))
          write_reg(CIDX_W'(r), pick_value(CIDX_W'(r)));
      end
      cfg_valid <= 1'b0;
      n_settings++;
      // long output stall while the sender keeps pushing
      if (in_idle_pct == 0) hold_req = 1'b1;
      repeat ($urandom_range(60, 10)) begin
        send_item(DET_W'($urandom_range(15)), 1'b0, '0);
        sent++;
      end
    end
    wait_quiet();

    $display("sent %0d sampling requests (%0d in curve order), %0d register writes, %0d settings",
             n_items, n_curve, n_writes, n_settings);
    $display("compared %0d samples, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
